// ===== design/lpr_pkg.sv =====
// Shared types, constants and helpers for the LRU page replacement core.
package lpr_pkg;

   // Field widths fixed by the interface.
   localparam int PAGE_W    = 19;
   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 32;
   localparam int SHIFT_W   = 4;
   localparam int LIMIT_W   = 7;
   localparam int FIDX_W    = 6;

   // One frame table entry: dirty, page number, last-use stamp.
   localparam int ENTRY_W   = 1 + PAGE_W + STAMP_W;
   localparam int ENT_DIRTY = ENTRY_W - 1;
   localparam int ENT_PAGE  = STAMP_W;

   // Defaults for the top level parameters.
   localparam int FRAMES_DEF    = 64;
   localparam int ADDR_BITS_DEF = 27;

   // Page shift limits and counter saturation value.
   localparam logic [SHIFT_W-1:0] MIN_SHIFT = 4'd8;
   localparam logic [SHIFT_W-1:0] MAX_SHIFT = 4'd13;
   localparam logic [CNT_W-1:0]   CNT_MAX   = '1;

   // Register file layout.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_PAGE_SHIFT    = 1'b0;
   localparam logic REG_FRAMES_IN_USE = 1'b1;
   localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST    = 4'd8;
   localparam logic [LIMIT_W-1:0] FRAMES_IN_USE_RST = 7'd64;

   // Configuration as seen by the engine.
   typedef struct packed {
      logic [SHIFT_W-1:0] page_shift;
      logic [LIMIT_W-1:0] frames_in_use;
   } lpr_cfg_type;

   // One result item.
   typedef struct packed {
      logic               fault;
      logic               replaced;
      logic               flushed;
      logic [PAGE_W-1:0]  victim_page;
      logic [FIDX_W-1:0]  frame_index;
      logic [CNT_W-1:0]   reference_count;
      logic [CNT_W-1:0]   fault_count;
      logic [CNT_W-1:0]   replacement_count;
      logic [CNT_W-1:0]   flush_count;
   } lpr_rsp_type;

   // Saturating increment for the statistics counters.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ===== design/lpr_frame_mem.sv =====
// Frame table memory: one write port and one registered read port.
module lpr_frame_mem #(
   parameter int DEPTH = lpr_pkg::FRAMES_DEF,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [lpr_pkg::ENTRY_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [lpr_pkg::ENTRY_W-1:0] rd_data
);
   import lpr_pkg::*;

   logic [ENTRY_W-1:0] ram [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/lpr_csr.sv =====
// Configuration registers behind an APB-style port.
module lpr_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lpr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lpr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready,
   output lpr_pkg::lpr_cfg_type           cfg
);
   import lpr_pkg::*;

   logic [SHIFT_W-1:0] page_shift_ff;
   logic [LIMIT_W-1:0] frames_in_use_ff;
   logic               reg_sel;
   logic               wr_strobe;

   // Registers are word aligned, so the word address picks one.
   assign reg_sel    = csr_paddr[2];
   assign wr_strobe  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         page_shift_ff    <= PAGE_SHIFT_RST;
         frames_in_use_ff <= FRAMES_IN_USE_RST;
      end else if (wr_strobe) begin
         unique case (reg_sel)
            REG_PAGE_SHIFT:    page_shift_ff    <= csr_pwdata[SHIFT_W-1:0];
            REG_FRAMES_IN_USE: frames_in_use_ff <= csr_pwdata[LIMIT_W-1:0];
            default:           page_shift_ff    <= page_shift_ff;
         endcase
      end
   end

   // Read data mux.
   always_comb begin
      unique case (reg_sel)
         REG_PAGE_SHIFT:    csr_prdata = CSR_DATA_W'(page_shift_ff);
         REG_FRAMES_IN_USE: csr_prdata = CSR_DATA_W'(frames_in_use_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg.page_shift    = page_shift_ff;
   assign cfg.frames_in_use = frames_in_use_ff;

endmodule

// ===== design/lpr_engine.sv =====
// Lookup, oldest-stamp search and update sequencer over the frame table memory.
module lpr_engine #(
   parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
   parameter int ADDR_BITS = lpr_pkg::ADDR_BITS_DEF,
   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  lpr_pkg::lpr_cfg_type        cfg,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ADDR_BITS-1:0]        req_address,
   input  logic                        out_free,
   output logic                        push,
   output lpr_pkg::lpr_rsp_type        rsp,
   output logic                        mem_rd_en,
   output logic [IDX_W-1:0]            mem_rd_addr,
   input  logic [lpr_pkg::ENTRY_W-1:0] mem_rd_data,
   output logic                        mem_wr_en,
   output logic [IDX_W-1:0]            mem_wr_addr,
   output logic [lpr_pkg::ENTRY_W-1:0] mem_wr_data
);
   import lpr_pkg::*;

   localparam int FILL_W = $clog2(FRAMES + 1);
   localparam int LIM_W  = (FILL_W > LIMIT_W) ? FILL_W : LIMIT_W;
   localparam int EXT_W  = ADDR_BITS + PAGE_W;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DECIDE = 2'd2;

   // Control state.
   logic [1:0]        state_ff;
   logic [FILL_W-1:0] issue_ff;
   logic              rd_vld_ff;
   logic              hit_ff;
   logic              found_ff;
   logic [FILL_W-1:0] filled_ff;
   logic [CNT_W-1:0]  ref_cnt_ff;
   logic [CNT_W-1:0]  fault_cnt_ff;
   logic [CNT_W-1:0]  repl_cnt_ff;
   logic [CNT_W-1:0]  flush_cnt_ff;

   // Per-reference working data.
   logic [PAGE_W-1:0]  page_ff;
   logic               wr_ff;
   logic [STAMP_W-1:0] stamp_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic [IDX_W-1:0]   hit_slot_ff;
   logic               hit_dirty_ff;
   logic [STAMP_W-1:0] old_stamp_ff;
   logic [IDX_W-1:0]   old_slot_ff;
   logic [PAGE_W-1:0]  old_page_ff;
   logic               old_dirty_ff;

   logic [SHIFT_W-1:0] eff_shift;
   logic [EXT_W-1:0]   addr_ext;
   logic [PAGE_W-1:0]  page_new;
   logic [LIM_W-1:0]   lim_raw;
   logic [LIM_W-1:0]   eff_limit;
   logic               scan_more;
   logic               ent_dirty;
   logic [PAGE_W-1:0]  ent_page;
   logic [STAMP_W-1:0] ent_stamp;
   logic               match;
   logic               older;
   logic               fill;
   logic               replace;
   logic               flush;
   logic [IDX_W-1:0]   slot;
   logic [CNT_W-1:0]   ref_next;
   logic [CNT_W-1:0]   fault_next;
   logic [CNT_W-1:0]   repl_next;
   logic [CNT_W-1:0]   flush_next;

   // Clamp the page shift and derive the page number of a new reference.
   always_comb begin
      if (cfg.page_shift < MIN_SHIFT) begin
         eff_shift = MIN_SHIFT;
      end else if (cfg.page_shift > MAX_SHIFT) begin
         eff_shift = MAX_SHIFT;
      end else begin
         eff_shift = cfg.page_shift;
      end
   end

   assign addr_ext = EXT_W'(req_address);
   assign page_new = PAGE_W'(addr_ext >> eff_shift);

   // Clamp the frame limit to 1..FRAMES.
   assign lim_raw = LIM_W'(cfg.frames_in_use);
   always_comb begin
      if (lim_raw == '0) begin
         eff_limit = LIM_W'(1);
      end else if (lim_raw > LIM_W'(FRAMES)) begin
         eff_limit = LIM_W'(FRAMES);
      end else begin
         eff_limit = lim_raw;
      end
   end

   // One reference is in work at a time.
   assign req_stall = (state_ff != ST_IDLE);

   // Scan issues one read per filled frame; filled frames are exactly the valid ones.
   assign scan_more   = (issue_ff < filled_ff);
   assign mem_rd_en   = (state_ff == ST_SCAN) && scan_more;
   assign mem_rd_addr = issue_ff[IDX_W-1:0];

   assign ent_dirty = mem_rd_data[ENT_DIRTY];
   assign ent_page  = mem_rd_data[ENT_PAGE +: PAGE_W];
   assign ent_stamp = mem_rd_data[STAMP_W-1:0];

   // The first match wins; on equal stamps the lower frame is kept.
   assign match = rd_vld_ff && !hit_ff && (ent_page == page_ff);
   assign older = rd_vld_ff && (!found_ff || (ent_stamp < old_stamp_ff));

   // Decision at the end of the scan.
   assign fill    = !hit_ff && (LIM_W'(filled_ff) < eff_limit);
   assign replace = !hit_ff && !fill;
   assign flush   = replace && old_dirty_ff;

   always_comb begin
      priority if (hit_ff) begin
         slot = hit_slot_ff;
      end else if (fill) begin
         slot = filled_ff[IDX_W-1:0];
      end else begin
         slot = old_slot_ff;
      end
   end

   assign push        = (state_ff == ST_DECIDE) && out_free;
   assign mem_wr_en   = push;
   assign mem_wr_addr = slot;
   assign mem_wr_data = {(hit_ff ? (hit_dirty_ff | wr_ff) : wr_ff), page_ff, stamp_ff};

   // Counter values after this reference.
   assign ref_next   = sat_inc(ref_cnt_ff);
   assign fault_next = hit_ff  ? fault_cnt_ff : sat_inc(fault_cnt_ff);
   assign repl_next  = replace ? sat_inc(repl_cnt_ff) : repl_cnt_ff;
   assign flush_next = flush   ? sat_inc(flush_cnt_ff) : flush_cnt_ff;

   // Result item.
   assign rsp.fault             = !hit_ff;
   assign rsp.replaced          = replace;
   assign rsp.flushed           = flush;
   assign rsp.victim_page       = replace ? old_page_ff : '0;
   assign rsp.frame_index       = FIDX_W'(slot);
   assign rsp.reference_count   = ref_next;
   assign rsp.fault_count       = fault_next;
   assign rsp.replacement_count = repl_next;
   assign rsp.flush_count       = flush_next;

   // Sequencer and statistics.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         issue_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         hit_ff       <= 1'b0;
         found_ff     <= 1'b0;
         filled_ff    <= '0;
         ref_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         repl_cnt_ff  <= '0;
         flush_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  issue_ff <= '0;
                  hit_ff   <= 1'b0;
                  found_ff <= 1'b0;
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               rd_vld_ff <= scan_more;
               if (scan_more) begin
                  issue_ff <= FILL_W'(issue_ff + 1'b1);
               end
               if (match) begin
                  hit_ff <= 1'b1;
               end
               if (older) begin
                  found_ff <= 1'b1;
               end
               if (!scan_more && !rd_vld_ff) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (out_free) begin
                  if (fill) begin
                     filled_ff <= FILL_W'(filled_ff + 1'b1);
                  end
                  ref_cnt_ff   <= ref_next;
                  fault_cnt_ff <= fault_next;
                  repl_cnt_ff  <= repl_next;
                  flush_cnt_ff <= flush_next;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Working data for the reference in flight.
   always_ff @(posedge clock) begin
      if ((state_ff == ST_IDLE) && req_valid) begin
         page_ff  <= page_new;
         wr_ff    <= req_address[0];
         stamp_ff <= ref_cnt_ff;
      end
      rd_idx_ff <= issue_ff[IDX_W-1:0];
      if (match) begin
         hit_slot_ff  <= rd_idx_ff;
         hit_dirty_ff <= ent_dirty;
      end
      if (older) begin
         old_stamp_ff <= ent_stamp;
         old_slot_ff  <= rd_idx_ff;
         old_page_ff  <= ent_page;
         old_dirty_ff <= ent_dirty;
      end
   end

   // The fill count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      filled_ff <= FILL_W'(FRAMES))
      else $error("frame fill count exceeds table size");

   // Faults and flushes never outrun the counts they are part of.
   assert property (@(posedge clock) disable iff (reset)
      (fault_cnt_ff <= ref_cnt_ff) && (flush_cnt_ff <= repl_cnt_ff))
      else $error("statistics counters out of order");

   // Read data only arrives while scanning.
   assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("frame read outside of scan");

   // An eviction always has a candidate from the scan.
   assert property (@(posedge clock) disable iff (reset)
      (push && replace) |-> found_ff)
      else $error("eviction without an oldest frame");

endmodule

// ===== design/lru_page_replacement_core.sv =====
// Top level of the LRU page replacement core.
//
//  Channel  Direction  Handshake                 Payload
//  req      in         req_valid / req_stall     req_reference_address
//  rsp      out        rsp_valid / rsp_stall     fault .. flush_count
//  csr      in/out     APB psel/penable/pready   page_shift, frames_in_use
//
// A reference is scanned after its transfer with one memory read per filled frame, for
// lookup and oldest-stamp search, then the chosen frame is written as the result
// register is loaded. The next transfer is taken once the engine is idle again.
// Reset clears the fill count and counters; frames need no clearing.
// The result register lets the next reference be taken while a result waits; a
// stalled result holds the final write until the register frees up.
module lru_page_replacement_core #(
   parameter int FRAMES    = lpr_pkg::FRAMES_DEF,
   parameter int ADDR_BITS = lpr_pkg::ADDR_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ADDR_BITS-1:0]           req_reference_address,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_fault,
   output logic                           rsp_replaced,
   output logic                           rsp_flushed,
   output logic [lpr_pkg::PAGE_W-1:0]     rsp_victim_page,
   output logic [lpr_pkg::FIDX_W-1:0]     rsp_frame_index,
   output logic [lpr_pkg::CNT_W-1:0]      rsp_reference_count,
   output logic [lpr_pkg::CNT_W-1:0]      rsp_fault_count,
   output logic [lpr_pkg::CNT_W-1:0]      rsp_replacement_count,
   output logic [lpr_pkg::CNT_W-1:0]      rsp_flush_count,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [lpr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lpr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lpr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import lpr_pkg::*;

   localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

   lpr_cfg_type        cfg;
   lpr_rsp_type        eng_rsp;
   logic               push;
   logic               out_free;
   logic               mem_rd_en;
   logic [IDX_W-1:0]   mem_rd_addr;
   logic [ENTRY_W-1:0] mem_rd_data;
   logic               mem_wr_en;
   logic [IDX_W-1:0]   mem_wr_addr;
   logic [ENTRY_W-1:0] mem_wr_data;
   logic               rsp_valid_ff;
   lpr_rsp_type        rsp_data_ff;

   lpr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   lpr_frame_mem #(
      .DEPTH (FRAMES)
   ) u_frame_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   lpr_engine #(
      .FRAMES    (FRAMES),
      .ADDR_BITS (ADDR_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_address (req_reference_address),
      .out_free    (out_free),
      .push        (push),
      .rsp         (eng_rsp),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   // The result register is free when empty or when its transfer completes now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= push;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= eng_rsp;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_fault             = rsp_data_ff.fault;
   assign rsp_replaced          = rsp_data_ff.replaced;
   assign rsp_flushed           = rsp_data_ff.flushed;
   assign rsp_victim_page       = rsp_data_ff.victim_page;
   assign rsp_frame_index       = rsp_data_ff.frame_index;
   assign rsp_reference_count   = rsp_data_ff.reference_count;
   assign rsp_fault_count       = rsp_data_ff.fault_count;
   assign rsp_replacement_count = rsp_data_ff.replacement_count;
   assign rsp_flush_count       = rsp_data_ff.flush_count;

endmodule

// ===== tb/tb_lru_page_replacement_core.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the LRU page replacement core.

module tb_lru_page_replacement_core;
   import lpr_pkg::*;

   // Mirror of the frame table that predicts the outcome of every reference
   // and holds the outcomes that have not come back from the core yet.
   class frame_table_mirror;
      logic [PAGE_W-1:0]  page_of  [FRAMES_DEF];
      bit                 valid_of [FRAMES_DEF];
      bit                 dirty_of [FRAMES_DEF];
      logic [STAMP_W-1:0] stamp_of [FRAMES_DEF];
      int unsigned        filled;
      logic [CNT_W-1:0]   refs;
      logic [CNT_W-1:0]   faults;
      logic [CNT_W-1:0]   replacements;
      logic [CNT_W-1:0]   flushes;
      logic [SHIFT_W-1:0] shift_reg;
      logic [LIMIT_W-1:0] limit_reg;
      lpr_rsp_type        pending_outcomes[$];
      int unsigned        mismatches;

      function new();
         for (int i = 0; i < FRAMES_DEF; i++) begin
            valid_of[i] = 1'b0;
            dirty_of[i] = 1'b0;
         end
         filled       = 0;
         refs         = '0;
         faults       = '0;
         replacements = '0;
         flushes      = '0;
         shift_reg    = PAGE_SHIFT_RST;
         limit_reg    = FRAMES_IN_USE_RST;
         mismatches   = 0;
      endfunction

      // Counters stick at their maximum value.
      function logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // The shift register is clamped to page sizes of 256 to 8192 bytes.
      function int effective_shift();
         if (shift_reg < 8) return 8;
         if (shift_reg > 13) return 13;
         return int'(shift_reg);
      endfunction

      function int effective_limit();
         if (limit_reg == 0) return 1;
         if (limit_reg > FRAMES_DEF) return FRAMES_DEF;
         return int'(limit_reg);
      endfunction

      function void write_register(input logic idx, input logic [31:0] value);
         if (idx == REG_PAGE_SHIFT) shift_reg = value[SHIFT_W-1:0];
         else limit_reg = value[LIMIT_W-1:0];
      endfunction

      function void field_check(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
         if (seen !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            mismatches++;
         end
      endfunction

      // Work out the outcome of one accepted reference and queue it.
      function void note_reference(input logic [ADDR_BITS_DEF-1:0] addr);
         lpr_rsp_type        out;
         logic [31:0]        wide;
         logic [PAGE_W-1:0]  page;
         logic [STAMP_W-1:0] stamp;
         logic [STAMP_W-1:0] oldest;
         bit                 is_write;
         bit                 hit;
         bit                 found;
         int                 slot;
         out      = '0;
         stamp    = refs;
         is_write = addr[0];
         wide     = 32'(addr) >> effective_shift();
         page     = wide[PAGE_W-1:0];
         hit      = 1'b0;
         slot     = 0;

         // The lowest matching frame wins the lookup.
         for (int i = 0; i < FRAMES_DEF; i++) begin
            if (valid_of[i] && page_of[i] == page) begin
               hit  = 1'b1;
               slot = i;
               break;
            end
         end

         if (hit) begin
            if (is_write) dirty_of[slot] = 1'b1;
            stamp_of[slot] = stamp;
         end else begin
            out.fault = 1'b1;
            faults    = bump(faults);
            if (filled < effective_limit()) begin
               slot = filled;
               filled++;
            end else begin
               // Evict the oldest valid frame; ties go to the lowest index.
               found  = 1'b0;
               oldest = '0;
               for (int i = 0; i < FRAMES_DEF; i++) begin
                  if (valid_of[i] && (!found || stamp_of[i] < oldest)) begin
                     found  = 1'b1;
                     oldest = stamp_of[i];
                     slot   = i;
                  end
               end
               out.replaced    = 1'b1;
               out.victim_page = page_of[slot];
               replacements    = bump(replacements);
               if (dirty_of[slot]) begin
                  out.flushed = 1'b1;
                  flushes     = bump(flushes);
               end
            end
            page_of[slot]  = page;
            valid_of[slot] = 1'b1;
            dirty_of[slot] = is_write;
            stamp_of[slot] = stamp;
         end

         refs                  = bump(refs);
         out.frame_index       = slot[FIDX_W-1:0];
         out.reference_count   = refs;
         out.fault_count       = faults;
         out.replacement_count = replacements;
         out.flush_count       = flushes;
         pending_outcomes      = {pending_outcomes, out};
      endfunction

      // Compare one accepted result with the oldest outstanding outcome.
      function void check_outcome(input lpr_rsp_type seen);
         lpr_rsp_type want;
         if (pending_outcomes.size() == 0) begin
            $error("result transfer with no reference outstanding");
            mismatches++;
            return;
         end
         want = pending_outcomes.pop_front();
         field_check("fault", 32'(want.fault), 32'(seen.fault));
         field_check("replaced", 32'(want.replaced), 32'(seen.replaced));
         field_check("flushed", 32'(want.flushed), 32'(seen.flushed));
         field_check("victim_page", 32'(want.victim_page), 32'(seen.victim_page));
         field_check("frame_index", 32'(want.frame_index), 32'(seen.frame_index));
         field_check("reference_count", want.reference_count, seen.reference_count);
         field_check("fault_count", want.fault_count, seen.fault_count);
         field_check("replacement_count", want.replacement_count,
                     seen.replacement_count);
         field_check("flush_count", want.flush_count, seen.flush_count);
      endfunction
   endclass

   localparam int ADDR_W      = ADDR_BITS_DEF;
   localparam int HOLD_CYCLES = 200;
   localparam int QUIET_LIMIT = 4000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ADDR_W-1:0]     req_reference_address;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_fault;
   logic                  rsp_replaced;
   logic                  rsp_flushed;
   logic [PAGE_W-1:0]     rsp_victim_page;
   logic [FIDX_W-1:0]     rsp_frame_index;
   logic [CNT_W-1:0]      rsp_reference_count;
   logic [CNT_W-1:0]      rsp_fault_count;
   logic [CNT_W-1:0]      rsp_replacement_count;
   logic [CNT_W-1:0]      rsp_flush_count;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_table_mirror mirror = new();
   lpr_rsp_type       seen_result;
   logic [PAGE_W-1:0] hot_pages[$];
   bit                hold_results = 1'b0;
   bit                calm = 1'b0;
   int                quiet_cycles = 0;

   lru_page_replacement_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_reference_address (req_reference_address),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_fault             (rsp_fault),
      .rsp_replaced          (rsp_replaced),
      .rsp_flushed           (rsp_flushed),
      .rsp_victim_page       (rsp_victim_page),
      .rsp_frame_index       (rsp_frame_index),
      .rsp_reference_count   (rsp_reference_count),
      .rsp_fault_count       (rsp_fault_count),
      .rsp_replacement_count (rsp_replacement_count),
      .rsp_flush_count       (rsp_flush_count),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Idle lengths are mostly zero or short, with an occasional long one.
   function automatic int idle_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // Offer one reference and hold it until the core takes the transfer.
   task automatic send_reference(input logic [ADDR_W-1:0] addr);
      int gap;
      gap = calm ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_reference_address <= addr;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mirror.note_reference(addr);
   endtask

   task automatic wait_for_results();
      while (mirror.pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Write one register while the core is idle, then read it back.
   task automatic program_register(input logic idx, input logic [31:0] value);
      logic [31:0] mask;
      req_valid <= 1'b0;
      wait_for_results();
      mask = (idx == REG_PAGE_SHIFT) ? 32'hF : 32'h7F;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mirror.write_register(idx, value);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      mirror.field_check((idx == REG_PAGE_SHIFT) ? "page_shift readback"
                                                 : "frames_in_use readback",
                         value & mask, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // One setting of the registers followed by random references. Most of
   // them revisit a small set of hot pages so that hits, evictions and
   // dirty flushes all occur; the rest are arbitrary addresses.
   task automatic run_phase(input logic [31:0] shift, input logic [31:0] limit,
                            input int count);
      int          s;
      logic [31:0] wide;
      program_register(REG_PAGE_SHIFT, shift);
      program_register(REG_FRAMES_IN_USE, limit);
      s = mirror.effective_shift();
      hot_pages.delete();
      repeat (mirror.effective_limit() + $urandom_range(1, 4)) begin
         wide      = $urandom & ((32'd1 << (ADDR_W - s)) - 1);
         hot_pages = {hot_pages, wide[PAGE_W-1:0]};
      end
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) begin
            wide = $urandom;
         end else begin
            wide = 32'(hot_pages[$urandom_range(0, hot_pages.size() - 1)]);
            wide = (wide << s) | ($urandom & ((32'd1 << s) - 1));
         end
         send_reference(wide[ADDR_W-1:0]);
      end
   endtask

   // Result side stall pattern, with one long hold-off on request.
   initial begin
      int len;
      rsp_stall <= 1'b0;
      forever begin
         repeat ($urandom_range(1, 6)) @(posedge clock);
         if (hold_results) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_results = 1'b0;
            rsp_stall <= 1'b0;
         end else if (!calm) begin
            len = idle_length();
            if (len > 0) begin
               rsp_stall <= 1'b1;
               repeat (len) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
      end
   end

   // Check every result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_result = {rsp_fault, rsp_replaced, rsp_flushed, rsp_victim_page,
                        rsp_frame_index, rsp_reference_count, rsp_fault_count,
                        rsp_replacement_count, rsp_flush_count};
         mirror.check_outcome(seen_result);
      end
   end

   // Give up when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_lru_page_replacement_core: errors");
         $finish;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
   end

   initial begin
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_reference_address <= '0;
      csr_psel              <= 1'b0;
      csr_penable           <= 1'b0;
      csr_pwrite            <= 1'b0;
      csr_paddr             <= '0;
      csr_pwdata            <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Address extremes, a write hit and free frame fills at reset settings.
      send_reference(27'h0000000);
      send_reference(27'h0000001);
      send_reference(27'h7FFFFFF);
      send_reference(27'h7FFFF00);
      send_reference(27'h0000100);

      // Limit below the filled frames: every miss evicts the oldest frame,
      // dirty victims are flushed. Out-of-range shift acts as the minimum.
      program_register(REG_FRAMES_IN_USE, 32'd0);
      program_register(REG_PAGE_SHIFT, 32'd0);
      send_reference(27'h0000200);
      send_reference(27'h0000301);
      send_reference(27'h0000100);
      send_reference(27'h0000000);

      // Shift changed with pages resident: stored page numbers still match.
      program_register(REG_PAGE_SHIFT, 32'd15);
      program_register(REG_FRAMES_IN_USE, 32'd127);
      send_reference(27'h0002000);
      send_reference(27'h0002001);
      send_reference(27'h7FFE000);
      send_reference(27'h0000000);

      run_phase(32'd9, 32'd1, 60);
      run_phase(32'd11, 32'd2, 80);
      run_phase(32'd10, 32'd8, 80);
      // Results are held back while references keep coming.
      program_register(REG_PAGE_SHIFT, 32'd12);
      program_register(REG_FRAMES_IN_USE, 32'd16);
      hold_results = 1'b1;
      run_phase(32'd12, 32'd16, 100);
      run_phase(32'd8, 32'd33, 80);
      calm = 1'b1;
      run_phase(32'd13, 32'd64, 120);
      calm = 1'b0;
      run_phase(32'd0, 32'd0, 60);
      run_phase(32'd15, 32'd127, 120);

      req_valid <= 1'b0;
      wait_for_results();
      repeat (FRAMES_DEF + 8) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("tb_lru_page_replacement_core: clean");
      end else begin
         $display("tb_lru_page_replacement_core: errors");
      end
      $finish;
   end
endmodule
